// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define MFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that a condition never occurs.
`define MFC_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// ----- rtl/core/mfc_pkg.sv -----
`default_nettype none

package mfc_pkg;

  localparam int NUM_BANKS = 10;
  localparam int NUM_SLOTS = 8;

  localparam int PROG_W      = 7;
  localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int BANK_W      = ($clog2(NUM_BANKS + 1) > 4) ? $clog2(NUM_BANKS + 1) : 4;
  localparam int BANK_IDX_W  = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int ROW_W       = NUM_SLOTS * PROG_W;

  localparam logic [BANK_W-1:0] BANK_MAX = BANK_W'(NUM_BANKS);
  localparam logic [BANK_W-1:0] BANK_MIN = BANK_W'(1);
  localparam logic [3:0]        SLOTS_L  = 4'(NUM_SLOTS);

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_IDX_W     = 2;
  localparam int Q_CNT_W     = 3;

  localparam logic [7:0]        CC_STATUS    = 8'hB0;
  localparam logic [7:0]        PC_STATUS    = 8'hC0;
  localparam logic [PROG_W-1:0] PROG_MAX     = 7'd127;
  localparam logic [PROG_W-1:0] FX_ON_VAL    = 7'd127;
  localparam logic [7:0]        PEDAL_OFFSET = 8'd3;
  localparam logic [7:0]        PEDAL_CLIP   = 8'd112;

  localparam logic [6:0] FX_BASE_RST   = 7'd64;
  localparam logic [6:0] EXPR_CTRL_RST = 7'd11;
  localparam logic [3:0] MIDI_CH_RST   = 4'd0;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_FX_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPR_CTRL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CH   = 2'd2;

  typedef enum logic [2:0] {
    FN_PEDAL = 3'd0,
    FN_INC   = 3'd1,
    FN_DEC   = 3'd2,
    FN_SAVE  = 3'd3,
    FN_LOAD  = 3'd4,
    FN_FSW   = 3'd5,
    FN_MODE  = 3'd6,
    FN_NONE  = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    OP_PEDAL,
    OP_INC,
    OP_DEC,
    OP_SAVE,
    OP_LOAD,
    OP_FSW,
    OP_MODE,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    UI_NORMAL = 2'd0,
    UI_SAVE   = 2'd1,
    UI_LOAD   = 2'd2
  } ui_t;

  typedef enum logic {
    EX_RUN,
    EX_LOAD
  } exec_t;

  typedef struct packed {
    op_t              op;
    logic [2:0]       idx;
    logic [PROG_W-1:0] value;
  } cmd_t;

  function automatic logic [PROG_W-1:0] bank_one_default(input logic [2:0] slot);
    logic [PROG_W-1:0] p;
    unique case (slot)
      3'd0:    p = 7'd9;
      3'd1:    p = 7'd11;
      3'd2:    p = 7'd12;
      3'd3:    p = 7'd13;
      3'd4:    p = 7'd11;
      3'd5:    p = 7'd13;
      3'd6:    p = 7'd9;
      default: p = 7'd12;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mfc_if.sv -----
`default_nettype none

interface mfc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [2:0] switch_index;
  logic [9:0] pedal_sample;

  modport source (output valid, func, switch_index, pedal_sample, input ready);
  modport sink   (input valid, func, switch_index, pedal_sample, output ready);
endinterface

interface mfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;
  logic       byte_valid;
  logic       last;
  logic [1:0] ui_state;
  logic [2:0] active_slot_out;
  logic [3:0] bank_number;
  logic       cc_mode_out;
  logic [6:0] slot_program;

  modport source (output valid, midi_byte, byte_valid, last, ui_state, active_slot_out,
                  bank_number, cc_mode_out, slot_program, input ready);
  modport sink   (input valid, midi_byte, byte_valid, last, ui_state, active_slot_out,
                  bank_number, cc_mode_out, slot_program, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/midi_footswitch_controller_top.sv -----
// channel   dir  handshake     payload
// in_ch     in   valid/ready   func, switch_index, pedal_sample
// out_ch    out  valid/ready   midi_byte, byte_valid, last, ui_state, active_slot_out,
//                              bank_number, cc_mode_out, slot_program
// cfg_*     in   cfg_we        cfg_index, cfg_wdata
//
// One word out per cycle while out_ch is ready: an event yields 1 to 3 result words through the
// single output register; a load confirm first reads the bank row, then sends its words.
// The first result word passes through the command queue and emit buffer to the output register.
// Four-deep command queue lets events be taken while earlier ones are still going out.
// rst_n is synchronous; bank rows are tracked by valid bits, so there is no clearing pass.
// out_ch stalls hold the output word and back up through the queue to in_ch.ready.
`default_nettype none

module midi_footswitch_controller_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  mfc_in_if.sink                              in_ch,
  mfc_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [mfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mfc_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  mfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  mfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/core/mfc_front.sv -----
`default_nettype none

module mfc_front (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mfc_in_if.sink     in_ch,
  output mfc_pkg::cmd_t cmd,
  output logic       cmd_valid,
  input  wire logic  cmd_pop
);

  mfc_pkg::cmd_t                       dec_cmd;
  logic [7:0]                          raw_q;
  logic [7:0]                          raw_off;
  logic                                push;
  mfc_pkg::cmd_t                       q_mem [mfc_pkg::QUEUE_DEPTH];
  logic [mfc_pkg::Q_IDX_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [mfc_pkg::Q_IDX_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [mfc_pkg::Q_CNT_W-1:0]         cnt_r, cnt_nxt;

  localparam logic [mfc_pkg::Q_IDX_W-1:0] PTR_LAST = mfc_pkg::Q_IDX_W'(mfc_pkg::QUEUE_DEPTH - 1);
  localparam logic [mfc_pkg::Q_CNT_W-1:0] CNT_FULL = mfc_pkg::Q_CNT_W'(mfc_pkg::QUEUE_DEPTH);

  // classify
  always_comb begin
    raw_q         = in_ch.pedal_sample[9:2];
    raw_off       = raw_q - mfc_pkg::PEDAL_OFFSET;
    dec_cmd.idx   = in_ch.switch_index;
    if (raw_q < mfc_pkg::PEDAL_OFFSET) begin
      dec_cmd.value = '0;
    end else if (raw_off > mfc_pkg::PEDAL_CLIP) begin
      dec_cmd.value = mfc_pkg::PROG_MAX;
    end else begin
      dec_cmd.value = raw_off[mfc_pkg::PROG_W-1:0];
    end
    unique case (mfc_pkg::func_t'(in_ch.func))
      mfc_pkg::FN_PEDAL: dec_cmd.op = mfc_pkg::OP_PEDAL;
      mfc_pkg::FN_INC:   dec_cmd.op = mfc_pkg::OP_INC;
      mfc_pkg::FN_DEC:   dec_cmd.op = mfc_pkg::OP_DEC;
      mfc_pkg::FN_SAVE:  dec_cmd.op = mfc_pkg::OP_SAVE;
      mfc_pkg::FN_LOAD:  dec_cmd.op = mfc_pkg::OP_LOAD;
      mfc_pkg::FN_FSW:   dec_cmd.op = ({1'b0, in_ch.switch_index} < mfc_pkg::SLOTS_L) ?
                                      mfc_pkg::OP_FSW : mfc_pkg::OP_NOP;
      mfc_pkg::FN_MODE:  dec_cmd.op = mfc_pkg::OP_MODE;
      mfc_pkg::FN_NONE:  dec_cmd.op = mfc_pkg::OP_NOP;
    endcase
  end

  // command queue
  assign in_ch.ready = (cnt_r != CNT_FULL);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != '0);
  assign cmd         = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= dec_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mfc_back.sv -----
`default_nettype none
`include "assert_macros.svh"

module mfc_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire mfc_pkg::cmd_t                     cmd,
  input  wire logic                              cmd_valid,
  output logic                                   cmd_pop,
  input  wire logic                              cfg_we,
  input  wire logic [mfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mfc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  mfc_out_if.source                              out_ch
);

  localparam int PW = mfc_pkg::PROG_W;
  localparam int SW = mfc_pkg::SLOT_IDX_W;
  localparam int NS = mfc_pkg::NUM_SLOTS;

  // config
  logic [6:0] fx_base_r;
  logic [6:0] expr_ctrl_r;
  logic [3:0] midi_ch_r;

  // preset state
  logic [PW-1:0]               working_r   [NS];
  logic [PW-1:0]               working_nxt [NS];
  logic [PW-1:0]               cur_prog_r, cur_prog_nxt;
  logic [2:0]                  active_slot_r, active_slot_nxt;
  logic [mfc_pkg::BANK_W-1:0]  bank_r, bank_nxt;
  logic                        cc_mode_r, cc_mode_nxt;
  logic [NS-1:0]               fx_tog_r, fx_tog_nxt;
  logic [PW-1:0]               last_expr_r, last_expr_nxt;
  mfc_pkg::ui_t                ui_r, ui_nxt;
  mfc_pkg::exec_t              ex_r, ex_nxt;

  // bank store, one row per bank
  logic [mfc_pkg::ROW_W-1:0]      store_mem [mfc_pkg::NUM_BANKS];
  logic [mfc_pkg::NUM_BANKS-1:0]  row_vld_r, row_vld_nxt;
  logic [mfc_pkg::ROW_W-1:0]      rd_row_r;
  logic                           rd_vld_r;
  logic                           rd_first_r;
  logic [mfc_pkg::ROW_W-1:0]      wr_row;
  logic [mfc_pkg::BANK_W-1:0]     bank_m1;
  logic [mfc_pkg::BANK_IDX_W-1:0] bank_idx;
  logic                           save_wr;
  logic [PW-1:0]                  load_prog [NS];

  // emitter
  logic [7:0] emit_buf_r [3];
  logic [7:0] emit_buf_nxt [3];
  logic [1:0] emit_cnt_r, emit_cnt_nxt;
  logic       emit_bv_r, emit_bv_nxt;
  logic       out_load;
  logic       emit_free;

  // output word
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_bv_r;
  logic       out_last_r;
  logic [1:0] out_ui_r;
  logic [2:0] out_slot_r;
  logic [3:0] out_bank_r;
  logic       out_cc_r;
  logic [6:0] out_prog_r;

  logic [7:0]    cc_status;
  logic [7:0]    pc_status;
  logic [SW-1:0] cmd_slot;
  logic [SW-1:0] act_slot;
  logic          new_tog;

  assign cc_status = mfc_pkg::CC_STATUS | {4'b0000, midi_ch_r};
  assign pc_status = mfc_pkg::PC_STATUS | {4'b0000, midi_ch_r};
  assign cmd_slot  = cmd.idx[SW-1:0];
  assign act_slot  = active_slot_r[SW-1:0];
  assign bank_m1   = bank_r - mfc_pkg::BANK_MIN;
  assign bank_idx  = bank_m1[mfc_pkg::BANK_IDX_W-1:0];

  assign out_load  = (emit_cnt_r != 2'd0) && (!out_valid_r || out_ch.ready);
  assign emit_free = (emit_cnt_r == 2'd0) || ((emit_cnt_r == 2'd1) && out_load);
  assign cmd_pop   = cmd_valid && (ex_r == mfc_pkg::EX_RUN) && emit_free;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      wr_row[i*PW +: PW] = working_r[i];
      if (rd_vld_r) begin
        load_prog[i] = rd_row_r[i*PW +: PW];
      end else if (rd_first_r) begin
        load_prog[i] = mfc_pkg::bank_one_default(3'(i));
      end else begin
        load_prog[i] = '0;
      end
    end
  end

  always_comb begin
    working_nxt     = working_r;
    cur_prog_nxt    = cur_prog_r;
    active_slot_nxt = active_slot_r;
    bank_nxt        = bank_r;
    cc_mode_nxt     = cc_mode_r;
    fx_tog_nxt      = fx_tog_r;
    last_expr_nxt   = last_expr_r;
    ui_nxt          = ui_r;
    ex_nxt          = ex_r;
    row_vld_nxt     = row_vld_r;
    save_wr         = 1'b0;
    new_tog         = ~fx_tog_r[cmd_slot];
    emit_buf_nxt    = emit_buf_r;
    emit_cnt_nxt    = emit_cnt_r;
    emit_bv_nxt     = emit_bv_r;

    if (out_load) begin
      emit_buf_nxt[0] = emit_buf_r[1];
      emit_buf_nxt[1] = emit_buf_r[2];
      emit_cnt_nxt    = emit_cnt_r - 2'd1;
    end

    if (ex_r == mfc_pkg::EX_LOAD) begin
      working_nxt     = load_prog;
      cur_prog_nxt    = load_prog[0];
      active_slot_nxt = '0;
      ui_nxt          = mfc_pkg::UI_NORMAL;
      ex_nxt          = mfc_pkg::EX_RUN;
      emit_buf_nxt[0] = pc_status;
      emit_buf_nxt[1] = {1'b0, load_prog[0]};
      emit_cnt_nxt    = 2'd2;
      emit_bv_nxt     = 1'b1;
    end else if (cmd_pop) begin
      // status-only unless an arm below sends bytes
      emit_buf_nxt[0] = '0;
      emit_cnt_nxt    = 2'd1;
      emit_bv_nxt     = 1'b0;
      unique case (cmd.op)
        mfc_pkg::OP_PEDAL: begin
          if (ui_r == mfc_pkg::UI_NORMAL && cmd.value != last_expr_r) begin
            last_expr_nxt   = cmd.value;
            emit_buf_nxt[0] = cc_status;
            emit_buf_nxt[1] = {1'b0, expr_ctrl_r};
            emit_buf_nxt[2] = {1'b0, cmd.value};
            emit_cnt_nxt    = 2'd3;
            emit_bv_nxt     = 1'b1;
          end
        end
        mfc_pkg::OP_INC: begin
          if (ui_r == mfc_pkg::UI_NORMAL) begin
            if (cur_prog_r != mfc_pkg::PROG_MAX) begin
              cur_prog_nxt          = cur_prog_r + 1'b1;
              working_nxt[act_slot] = cur_prog_r + 1'b1;
            end
          end else if (bank_r < mfc_pkg::BANK_MAX) begin
            bank_nxt = bank_r + 1'b1;
          end
        end
        mfc_pkg::OP_DEC: begin
          if (ui_r == mfc_pkg::UI_NORMAL) begin
            if (cur_prog_r != '0) begin
              cur_prog_nxt          = cur_prog_r - 1'b1;
              working_nxt[act_slot] = cur_prog_r - 1'b1;
            end
          end else if (bank_r > mfc_pkg::BANK_MIN) begin
            bank_nxt = bank_r - 1'b1;
          end
        end
        mfc_pkg::OP_SAVE: begin
          if (ui_r == mfc_pkg::UI_NORMAL) begin
            ui_nxt = mfc_pkg::UI_SAVE;
          end else if (ui_r == mfc_pkg::UI_SAVE) begin
            save_wr               = 1'b1;
            row_vld_nxt[bank_idx] = 1'b1;
            ui_nxt                = mfc_pkg::UI_NORMAL;
          end
        end
        mfc_pkg::OP_LOAD: begin
          if (ui_r == mfc_pkg::UI_NORMAL) begin
            ui_nxt = mfc_pkg::UI_LOAD;
          end else if (ui_r == mfc_pkg::UI_LOAD) begin
            // row read is under way; the row is applied next cycle
            ex_nxt       = mfc_pkg::EX_LOAD;
            emit_cnt_nxt = 2'd0;
          end
        end
        mfc_pkg::OP_FSW: begin
          if (ui_r == mfc_pkg::UI_NORMAL) begin
            if (!cc_mode_r) begin
              active_slot_nxt = cmd.idx;
              cur_prog_nxt    = working_r[cmd_slot];
              emit_buf_nxt[0] = pc_status;
              emit_buf_nxt[1] = {1'b0, working_r[cmd_slot]};
              emit_cnt_nxt    = 2'd2;
              emit_bv_nxt     = 1'b1;
            end else begin
              fx_tog_nxt[cmd_slot] = new_tog;
              emit_buf_nxt[0]      = cc_status;
              emit_buf_nxt[1]      = {1'b0, 7'(fx_base_r + 7'(cmd.idx))};
              emit_buf_nxt[2]      = {1'b0, (new_tog ? mfc_pkg::FX_ON_VAL : 7'd0)};
              emit_cnt_nxt         = 2'd3;
              emit_bv_nxt          = 1'b1;
            end
          end
        end
        mfc_pkg::OP_MODE: begin
          if (ui_r == mfc_pkg::UI_NORMAL) begin
            cc_mode_nxt = ~cc_mode_r;
          end
        end
        mfc_pkg::OP_NOP: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_base_r   <= mfc_pkg::FX_BASE_RST;
      expr_ctrl_r <= mfc_pkg::EXPR_CTRL_RST;
      midi_ch_r   <= mfc_pkg::MIDI_CH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfc_pkg::CFG_FX_BASE:   fx_base_r   <= cfg_wdata;
        mfc_pkg::CFG_EXPR_CTRL: expr_ctrl_r <= cfg_wdata;
        mfc_pkg::CFG_MIDI_CH:   midi_ch_r   <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        working_r[i] <= mfc_pkg::bank_one_default(3'(i));
      end
      cur_prog_r    <= mfc_pkg::bank_one_default(3'd0);
      active_slot_r <= '0;
      bank_r        <= mfc_pkg::BANK_MIN;
      cc_mode_r     <= 1'b0;
      fx_tog_r      <= '0;
      last_expr_r   <= '0;
      ui_r          <= mfc_pkg::UI_NORMAL;
      ex_r          <= mfc_pkg::EX_RUN;
      row_vld_r     <= '0;
      emit_cnt_r    <= 2'd0;
    end else begin
      working_r     <= working_nxt;
      cur_prog_r    <= cur_prog_nxt;
      active_slot_r <= active_slot_nxt;
      bank_r        <= bank_nxt;
      cc_mode_r     <= cc_mode_nxt;
      fx_tog_r      <= fx_tog_nxt;
      last_expr_r   <= last_expr_nxt;
      ui_r          <= ui_nxt;
      ex_r          <= ex_nxt;
      row_vld_r     <= row_vld_nxt;
      emit_cnt_r    <= emit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emit_buf_r <= emit_buf_nxt;
    emit_bv_r  <= emit_bv_nxt;
  end

  always_ff @(posedge clk) begin
    if (save_wr) begin
      store_mem[bank_idx] <= wr_row;
    end
    rd_row_r   <= store_mem[bank_idx];
    rd_vld_r   <= row_vld_r[bank_idx];
    rd_first_r <= (bank_idx == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= emit_buf_r[0];
      out_bv_r   <= emit_bv_r;
      out_last_r <= (emit_cnt_r == 2'd1);
      out_ui_r   <= ui_r;
      out_slot_r <= active_slot_r;
      out_bank_r <= bank_r[3:0];
      out_cc_r   <= cc_mode_r;
      out_prog_r <= cur_prog_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.midi_byte       = out_byte_r;
  assign out_ch.byte_valid      = out_bv_r;
  assign out_ch.last            = out_last_r;
  assign out_ch.ui_state        = out_ui_r;
  assign out_ch.active_slot_out = out_slot_r;
  assign out_ch.bank_number     = out_bank_r;
  assign out_ch.cc_mode_out     = out_cc_r;
  assign out_ch.slot_program    = out_prog_r;

  `MFC_ASSERT(a_prog_shadow, cur_prog_r == working_r[act_slot], "active program copy out of step")
  `MFC_ASSERT(a_status_only, out_valid_r && !out_bv_r |-> out_byte_r == 8'h00 && out_last_r, "malformed status-only word")
  `MFC_NEVER(a_byte_in_choice, out_valid_r && out_bv_r && out_ui_r != mfc_pkg::UI_NORMAL, "MIDI byte sent while choosing a bank")
  `MFC_ASSERT(a_load_emits, ex_r == mfc_pkg::EX_LOAD |=> ex_r == mfc_pkg::EX_RUN && emit_cnt_r == 2'd2, "load confirm did not queue program change")

endmodule

`default_nettype wire

// ----- tb/midi_event_checker.sv -----
module midi_event_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  mfc_in_if                              in_ch,
  mfc_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [mfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             outstanding,
  output int                             fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import mfc_pkg::*;

  typedef struct packed {
    logic [7:0] midi_byte;
    logic       byte_valid;
    logic       last;
    logic [1:0] ui_state;
    logic [2:0] slot;
    logic [3:0] bank;
    logic       cc_mode;
    logic [6:0] prog;
  } midi_word_t;

  midi_word_t expected_words[$];

  logic [6:0] bank_store [NUM_BANKS*NUM_SLOTS];
  logic [6:0] programs [NUM_SLOTS];
  logic       fx_on [NUM_SLOTS];
  logic [2:0] cur_slot;
  logic [3:0] cur_bank;
  logic       cc_mode;
  logic [6:0] last_expr;
  ui_t        ui;

  logic [6:0] fx_base;
  logic [6:0] expr_ctrl;
  logic [3:0] chan;

  int errs = 0;

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errs++;
      if (errs <= 40)
        $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  task automatic predict_event(input func_t fn, input logic [2:0] idx, input logic [9:0] raw);
    logic [7:0] bytes [3];
    logic [7:0] level;
    int         n;
    int         base;
    midi_word_t w;
    n = 0;
    case (fn)
      FN_PEDAL: if (ui == UI_NORMAL) begin
        level = raw[9:2];
        if (level < 8'd3) level = 8'd0;
        else level = level - 8'd3;
        if (level > 8'd112) level = 8'd127;
        if (level[6:0] != last_expr) begin
          bytes[0]  = 8'hB0 | {4'h0, chan};
          bytes[1]  = {1'b0, expr_ctrl};
          bytes[2]  = level;
          n         = 3;
          last_expr = level[6:0];
        end
      end
      FN_INC: begin
        if (ui == UI_NORMAL) begin
          if (programs[cur_slot] != 7'd127) programs[cur_slot] += 7'd1;
        end else if (int'(cur_bank) < NUM_BANKS) begin
          cur_bank += 4'd1;
        end
      end
      FN_DEC: begin
        if (ui == UI_NORMAL) begin
          if (programs[cur_slot] != 7'd0) programs[cur_slot] -= 7'd1;
        end else if (cur_bank > 4'd1) begin
          cur_bank -= 4'd1;
        end
      end
      FN_SAVE: begin
        if (ui == UI_NORMAL) begin
          ui = UI_SAVE;
        end else if (ui == UI_SAVE) begin
          base = (int'(cur_bank) - 1) * NUM_SLOTS;
          for (int i = 0; i < NUM_SLOTS; i++) bank_store[base + i] = programs[i];
          ui = UI_NORMAL;
        end
      end
      FN_LOAD: begin
        if (ui == UI_NORMAL) begin
          ui = UI_LOAD;
        end else if (ui == UI_LOAD) begin
          base = (int'(cur_bank) - 1) * NUM_SLOTS;
          for (int i = 0; i < NUM_SLOTS; i++) programs[i] = bank_store[base + i];
          cur_slot = 3'd0;
          bytes[0] = 8'hC0 | {4'h0, chan};
          bytes[1] = {1'b0, programs[0]};
          n        = 2;
          ui       = UI_NORMAL;
        end
      end
      FN_FSW: if (ui == UI_NORMAL && int'(idx) < NUM_SLOTS) begin
        if (!cc_mode) begin
          bytes[0] = 8'hC0 | {4'h0, chan};
          bytes[1] = {1'b0, programs[idx]};
          n        = 2;
          cur_slot = idx;
        end else begin
          fx_on[idx] = !fx_on[idx];
          bytes[0]   = 8'hB0 | {4'h0, chan};
          bytes[1]   = {1'b0, 7'(fx_base + 7'(idx))};
          bytes[2]   = fx_on[idx] ? 8'd127 : 8'd0;
          n          = 3;
        end
      end
      FN_MODE: if (ui == UI_NORMAL) cc_mode = !cc_mode;
      default: ;
    endcase

    w.ui_state = ui;
    w.slot     = cur_slot;
    w.bank     = cur_bank;
    w.cc_mode  = cc_mode;
    w.prog     = programs[cur_slot];
    if (n == 0) begin
      w.midi_byte  = 8'd0;
      w.byte_valid = 1'b0;
      w.last       = 1'b1;
      expected_words.push_back(w);
    end else begin
      for (int k = 0; k < n; k++) begin
        w.midi_byte  = bytes[k];
        w.byte_valid = 1'b1;
        w.last       = (k == n - 1);
        expected_words.push_back(w);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    midi_word_t got;
    midi_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANKS*NUM_SLOTS; i++) bank_store[i] = 7'd0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        bank_store[i] = bank_one_default(3'(i));
        programs[i]   = bank_one_default(3'(i));
        fx_on[i]      = 1'b0;
      end
      cur_slot  = 3'd0;
      cur_bank  = 4'd1;
      cc_mode   = 1'b0;
      last_expr = 7'd0;
      ui        = UI_NORMAL;
      fx_base   = 7'd64;
      expr_ctrl = 7'd11;
      chan      = 4'd0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FX_BASE:   fx_base   = cfg_wdata;
          CFG_EXPR_CTRL: expr_ctrl = cfg_wdata;
          CFG_MIDI_CH:   chan      = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.midi_byte, out_ch.byte_valid, out_ch.last, out_ch.ui_state,
                out_ch.active_slot_out, out_ch.bank_number, out_ch.cc_mode_out,
                out_ch.slot_program};
        if (expected_words.size() == 0) begin
          errs++;
          if (errs <= 40)
            $display("%0t ns: unexpected word expected none got %h", $time, got);
        end else begin
          want = expected_words.pop_front();
          check_field("midi_byte", want.midi_byte, got.midi_byte);
          check_field("byte_valid", want.byte_valid, got.byte_valid);
          check_field("last", want.last, got.last);
          check_field("ui_state", want.ui_state, got.ui_state);
          check_field("active_slot_out", want.slot, got.slot);
          check_field("bank_number", want.bank, got.bank);
          check_field("cc_mode_out", want.cc_mode, got.cc_mode);
          check_field("slot_program", want.prog, got.prog);
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_event(func_t'(in_ch.func), in_ch.switch_index, in_ch.pedal_sample);
    end
    outstanding <= expected_words.size();
    fail_count  <= errs;
  end
endmodule

// ----- tb/tb_midi_footswitch_controller_top.sv -----
module tb_midi_footswitch_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mfc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC,
    RX_CHOKED
  } rx_mode_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int outstanding;
  int fail_count;
  int cycles     = 0;
  int burst_left = 0;
  int items_sent = 0;

  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;

  mfc_in_if  in_ch ();
  mfc_out_if out_ch ();

  midi_footswitch_controller_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  midi_event_checker u_midi_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stall pattern, re-chosen whenever its run count expires
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 80);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE:     out_ch.ready <= 1'b1;
      RX_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_ch.ready <= (rx_left % 5) < 2;
      default:     out_ch.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic send_event(input func_t fn, input logic [2:0] idx, input logic [9:0] raw);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= fn;
    in_ch.switch_index <= idx;
    in_ch.pedal_sample <= raw;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_config(input logic [6:0] fx, input logic [6:0] expr, input logic [3:0] ch);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FX_BASE;
    cfg_wdata <= fx;
    @(posedge clk);
    cfg_index <= CFG_EXPR_CTRL;
    cfg_wdata <= expr;
    @(posedge clk);
    cfg_index <= CFG_MIDI_CH;
    cfg_wdata <= {3'b000, ch};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [9:0] pick_pedal();
    case ($urandom_range(0, 7))
      0:       return 10'd0;
      1:       return 10'd1023;
      2:       return 10'($urandom_range(0, 15));
      3:       return 10'($urandom_range(455, 470));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // bank choosing sequence: enter, move bank, maybe stray events, usually confirm
  task automatic bank_sequence(input func_t fn);
    int steps;
    int up_bias;
    send_event(fn, 3'($urandom), 10'($urandom));
    steps   = $urandom_range(0, 12);
    up_bias = $urandom_range(0, 3);
    for (int k = 0; k < steps; k++) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0:       send_event(FN_PEDAL, 3'($urandom), pick_pedal());
          1:       send_event(FN_FSW, 3'($urandom), 10'($urandom));
          2:       send_event(FN_MODE, 3'($urandom), 10'($urandom));
          default: send_event(fn == FN_SAVE ? FN_LOAD : FN_SAVE, 3'($urandom), 10'($urandom));
        endcase
      end
      send_event($urandom_range(0, 3) < up_bias ? FN_INC : FN_DEC, 3'($urandom),
                 10'($urandom));
    end
    if ($urandom_range(0, 9) != 0) send_event(fn, 3'($urandom), 10'($urandom));
  endtask

  task automatic run_random_events(input int count);
    int start;
    int pick;
    int len;
    func_t dir;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_event(FN_PEDAL, 3'($urandom), pick_pedal());
      end else if (pick < 35) begin
        dir = $urandom_range(0, 1) ? FN_INC : FN_DEC;
        len = $urandom_range(1, 15);
        repeat (len) send_event(dir, 3'($urandom), 10'($urandom));
      end else if (pick < 55) begin
        send_event(FN_FSW, 3'($urandom), 10'($urandom));
      end else if (pick < 62) begin
        send_event(FN_MODE, 3'($urandom), 10'($urandom));
      end else if (pick < 72) begin
        bank_sequence(FN_SAVE);
      end else if (pick < 82) begin
        bank_sequence(FN_LOAD);
      end else if (pick < 97) begin
        send_event(func_t'($urandom_range(0, 7)), 3'($urandom), 10'($urandom));
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FN_NONE;
    in_ch.switch_index <= 3'd0;
    in_ch.pedal_sample <= 10'd0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_FX_BASE;
    cfg_wdata          <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(7'd64, 7'd11, 4'd0);
    send_event(FN_PEDAL, 3'd0, 10'd0);
    send_event(FN_PEDAL, 3'd7, 10'd1023);
    send_event(FN_PEDAL, 3'd0, 10'd11);
    send_event(FN_PEDAL, 3'd0, 10'd12);
    send_event(FN_PEDAL, 3'd0, 10'd463);
    send_event(FN_PEDAL, 3'd0, 10'd464);
    send_event(FN_INC, 3'd0, 10'd0);
    send_event(FN_DEC, 3'd0, 10'd0);
    send_event(FN_FSW, 3'd7, 10'd0);
    send_event(FN_FSW, 3'd0, 10'd0);
    send_event(FN_MODE, 3'd0, 10'd0);
    send_event(FN_FSW, 3'd3, 10'd0);
    send_event(FN_FSW, 3'd3, 10'd0);
    send_event(FN_MODE, 3'd0, 10'd0);
    send_event(FN_NONE, 3'd5, 10'd1023);
    // stray events while choosing a bank
    send_event(FN_SAVE, 3'd0, 10'd0);
    send_event(FN_PEDAL, 3'd0, 10'd800);
    send_event(FN_FSW, 3'd2, 10'd0);
    send_event(FN_MODE, 3'd0, 10'd0);
    send_event(FN_LOAD, 3'd0, 10'd0);
    send_event(FN_INC, 3'd0, 10'd0);
    send_event(FN_SAVE, 3'd0, 10'd0);
    send_event(FN_LOAD, 3'd0, 10'd0);
    send_event(FN_DEC, 3'd0, 10'd0);
    send_event(FN_DEC, 3'd0, 10'd0);
    send_event(FN_LOAD, 3'd0, 10'd0);
    // drive slot 0 up to the program ceiling
    repeat (120) send_event(FN_INC, 3'($urandom), 10'($urandom));
    run_random_events(60);
    drain_results();

    set_config(7'd0, 7'd0, 4'd15);
    run_random_events(80);
    drain_results();

    set_config(7'd120, 7'd127, 4'd9);
    run_random_events(80);
    drain_results();

    set_config(7'($urandom_range(0, 120)), 7'($urandom_range(0, 127)),
               4'($urandom_range(0, 15)));
    run_random_events(80);
    drain_results();

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
